FILE: sv/nbq_pkg.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder package
// Shared types, register indexes and the first-level name encoding.
// ----------------------------------------------------------------------------
package nbq_pkg;

  localparam logic [3:0] MAX_NAME_CHARS = 4'd15;
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam logic [7:0] CFG_NAME_FIRST = 8'd0;
  localparam logic [7:0] CFG_NAME_LAST  = 8'd1;
  localparam logic [7:0] CFG_NAME_LEN   = 8'd2;
  localparam logic [7:0] CFG_LOCAL_ADDR = 8'd3;

  localparam logic [5:0] RESP_LAST_POS = 6'd61;
  localparam logic [5:0] MIN_LAST_POS  = 6'd45;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_word_t;

  typedef struct packed {
    logic [63:0] name_first;
    logic [55:0] name_last;
    logic [3:0]  name_len;
    logic [31:0] local_addr;
  } cfg_t;

  typedef struct packed {
    logic [15:0] tid;
  } job_t;

  // Encoded name byte k (0..31) of the padded, uppercased configured name.
  function automatic logic [7:0] enc_byte(input cfg_t cfg, input logic [4:0] k);
    logic [3:0] i;
    logic [3:0] used;
    logic [7:0] c;
    logic [7:0] r;
    logic [3:0] nib;
    i    = k[4:1];
    used = (cfg.name_len > MAX_NAME_CHARS) ? MAX_NAME_CHARS : cfg.name_len;
    if (i[3]) begin
      c = 8'(cfg.name_last >> {3'd6 - i[2:0], 3'b000});
    end else begin
      c = 8'(cfg.name_first >> {3'd7 - i[2:0], 3'b000});
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    if (i == 4'd15) begin
      r = 8'h00;
    end else if (i >= used) begin
      r = 8'h20;
    end else begin
      r = c;
    end
    nib = k[0] ? r[3:0] : r[7:4];
    return 8'h41 + {4'b0000, nib};
  endfunction

endpackage

FILE: sv/nbq_front.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder front end
// Takes query bytes, captures the id, runs the checks, queues answer jobs.
// ----------------------------------------------------------------------------
module nbq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nbq_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  input  nbq_pkg::in_word_t in_word_i,
  input  logic             job_full_i,
  output logic             in_ready_o,
  output logic             job_push_o,
  output nbq_pkg::job_t    job_o
);

  logic [5:0]  pos_q, pos_d;
  logic [15:0] tid_q, tid_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic        qn_q, qn_d;
  logic        name_ok_q, name_ok_d;
  logic        accept;
  logic        eop;
  logic [7:0]  b;
  logic [5:0]  name_idx;
  logic        pass;

  assign in_ready_o = ~job_full_i;
  assign accept     = in_valid_i & ~job_full_i;
  assign b          = in_word_i.rx_byte;
  assign eop        = in_word_i.end_of_packet;
  assign name_idx   = pos_q - 6'd13;

  always_comb begin
    tid_d     = tid_q;
    hdr_ok_d  = hdr_ok_q;
    qn_d      = qn_q;
    name_ok_d = name_ok_q;
    if (pos_q == 6'd0) begin
      tid_d = {b, tid_q[7:0]};
    end else if (pos_q == 6'd1) begin
      tid_d = {tid_q[15:8], b};
    end else if (pos_q == 6'd2) begin
      if ((b & 8'hF8) != 8'h00) hdr_ok_d = 1'b0;
    end else if (pos_q == 6'd4 || pos_q == 6'd5) begin
      if (b != 8'h00) qn_d = 1'b1;
    end else if (pos_q == 6'd12) begin
      if (b != 8'h20) name_ok_d = 1'b0;
    end else if (pos_q > 6'd12 && pos_q < 6'd45) begin
      if (b != nbq_pkg::enc_byte(cfg_i, name_idx[4:0])) name_ok_d = 1'b0;
    end
    pass = (pos_q >= nbq_pkg::MIN_LAST_POS) & hdr_ok_d & qn_d & name_ok_d;
    pos_d = (pos_q == 6'd63) ? pos_q : pos_q + 6'd1;
  end

  assign job_push_o = accept & eop & pass;
  assign job_o.tid  = tid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      tid_q     <= '0;
      hdr_ok_q  <= 1'b1;
      qn_q      <= 1'b0;
      name_ok_q <= 1'b1;
    end else if (accept) begin
      if (eop) begin
        pos_q     <= '0;
        tid_q     <= '0;
        hdr_ok_q  <= 1'b1;
        qn_q      <= 1'b0;
        name_ok_q <= 1'b1;
      end else begin
        pos_q     <= pos_d;
        tid_q     <= tid_d;
        hdr_ok_q  <= hdr_ok_d;
        qn_q      <= qn_d;
        name_ok_q <= name_ok_d;
      end
    end
  end

endmodule

FILE: sv/nbq_job_fifo.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder job queue
// Short queue of accepted queries between the front end and the back end.
// ----------------------------------------------------------------------------
module nbq_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nbq_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output nbq_pkg::job_t job_o,
  output logic          empty_o
);

  nbq_pkg::job_t                   mem_q [nbq_pkg::JOB_DEPTH];
  logic [nbq_pkg::JOB_PTR_W-1:0]   wr_q, rd_q;
  logic [nbq_pkg::JOB_CNT_W-1:0]   cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == nbq_pkg::JOB_CNT_W'(nbq_pkg::JOB_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == nbq_pkg::JOB_PTR_W'(nbq_pkg::JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == nbq_pkg::JOB_PTR_W'(nbq_pkg::JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push & ~do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop & ~do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/nbq_back.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder back end
// Streams the 62-byte positive answer record for each queued job.
// ----------------------------------------------------------------------------
module nbq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nbq_pkg::cfg_t     cfg_i,
  input  logic              job_empty_i,
  input  nbq_pkg::job_t     job_i,
  output logic              job_pop_o,
  input  logic              out_pop_i,
  output logic              out_valid_o,
  output nbq_pkg::out_word_t out_word_o
);

  logic               busy_q;
  logic [5:0]         cnt_q;
  logic [15:0]        tid_q;
  logic               out_valid_q;
  nbq_pkg::out_word_t out_word_q;
  logic               slot_free;
  logic               emit;
  logic [7:0]         resp;
  logic [5:0]         name_idx;

  assign slot_free   = ~out_valid_q | out_pop_i;
  assign emit        = busy_q & slot_free;
  assign job_pop_o   = ~busy_q & ~job_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign name_idx    = cnt_q - 6'd13;

  always_comb begin
    case (cnt_q)
      6'd0:    resp = tid_q[15:8];
      6'd1:    resp = tid_q[7:0];
      6'd2:    resp = 8'h85;
      6'd7:    resp = 8'h01;
      6'd12:   resp = 8'h20;
      6'd47:   resp = 8'h20;
      6'd49:   resp = 8'h01;
      6'd52:   resp = 8'h01;
      6'd53:   resp = 8'h2C;
      6'd55:   resp = 8'h06;
      6'd58:   resp = cfg_i.local_addr[31:24];
      6'd59:   resp = cfg_i.local_addr[23:16];
      6'd60:   resp = cfg_i.local_addr[15:8];
      6'd61:   resp = cfg_i.local_addr[7:0];
      default: begin
        if (cnt_q > 6'd12 && cnt_q < 6'd45) begin
          resp = nbq_pkg::enc_byte(cfg_i, name_idx[4:0]);
        end else begin
          resp = 8'h00;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      tid_q <= job_i.tid;
    end
    if (emit) begin
      out_word_q.tx_byte <= resp;
      out_word_q.tx_last <= (cnt_q == nbq_pkg::RESP_LAST_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == nbq_pkg::RESP_LAST_POS) begin
          busy_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/netbios_name_query_responder_top.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder
// Answers a matching NetBIOS name query with a positive name query response.
// ----------------------------------------------------------------------------
// Channel   Handshake               Word
// input     push / full             in_word_i  (rx_byte, end_of_packet)
// result    pop / empty             out_word_o (tx_byte, tx_last)
// config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front end takes one query byte per cycle unless the job queue is full.
// A passing query becomes a job in a two-entry queue; full rises only when
// two answers are still waiting to start. The back end sends one answer byte
// per cycle while pop is held. Reset is asynchronous and needs no clearing
// pass; configuration is always taken.
// ----------------------------------------------------------------------------
module netbios_name_query_responder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  nbq_pkg::in_word_t  in_word_i,
  input  logic               pop,
  output logic               empty,
  output nbq_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  nbq_pkg::cfg_t cfg_q;
  nbq_pkg::job_t fr_job, bk_job;
  logic          fr_ready, job_push, job_full, job_pop, job_empty, out_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = ~fr_ready;
  assign empty       = ~out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nbq_pkg::CFG_NAME_FIRST: cfg_q.name_first <= cfg_data_i;
        nbq_pkg::CFG_NAME_LAST:  cfg_q.name_last  <= cfg_data_i[55:0];
        nbq_pkg::CFG_NAME_LEN:   cfg_q.name_len   <= cfg_data_i[3:0];
        nbq_pkg::CFG_LOCAL_ADDR: cfg_q.local_addr <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  nbq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (push),
    .in_word_i  (in_word_i),
    .job_full_i (job_full),
    .in_ready_o (fr_ready),
    .job_push_o (job_push),
    .job_o      (fr_job)
  );

  nbq_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (fr_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (bk_job),
    .empty_o (job_empty)
  );

  nbq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (job_empty),
    .job_i       (bk_job),
    .job_pop_o   (job_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: sv/nbq_checker.sv
// ----------------------------------------------------------------------------
// NetBIOS name query responder checker
// Port-level checks on the framing of the answer words.
// ----------------------------------------------------------------------------
module nbq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pop,
  input logic               empty,
  input nbq_pkg::out_word_t out_word_o
);

  logic [5:0] seen_q;
  logic       taken;

  assign taken = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (taken) begin
      seen_q <= out_word_o.tx_last ? 6'd0 : seen_q + 6'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("Waiting answer word changed or vanished.");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken |-> (out_word_o.tx_last == (seen_q == nbq_pkg::RESP_LAST_POS)))
    else $error("Last mark not on the 62nd answer word.");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && seen_q == 6'd2) |-> (out_word_o.tx_byte == 8'h85))
    else $error("Answer flags byte is wrong.");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken && seen_q == 6'd12) |-> (out_word_o.tx_byte == 8'h20))
    else $error("Answer name length byte is wrong.");

endmodule

bind netbios_name_query_responder_top nbq_checker u_nbq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .out_word_o (out_word_o)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NetBIOS name query responder testbench
// Streams query packets into the responder one byte word at a time and checks
// every answer word against a predictor of the query checks and of the answer
// record. A table of directed queries covering header, length and name faults
// comes first, then random queries, mostly well formed, with random stalls on
// both handshakes and register changes between packets.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int ITEM_TARGET    = 310;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_HOLD       = 70;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 17;
  localparam int LEN_BYTE_POS   = 12;
  localparam int NAME_END_POS   = 44;
  localparam int MIN_QUERY_LEN  = 46;
  localparam int ANSWER_WORDS   = 62;
  localparam logic [6:0] NO_FAULT = 7'h7F;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [2:0] {SET_KEEP, SET_BASE, SET_FULL, SET_BLANK, SET_ODD} preset_e;
  typedef enum logic [1:0] {V_ANSWER, V_SILENT, V_MODEL} verdict_e;

  typedef struct packed {
    logic [63:0] first;
    logic [55:0] last;
    logic [3:0]  len;
    logic [31:0] addr;
  } name_cfg_t;

  typedef struct packed {
    preset_e     preset;
    logic [15:0] tid;
    logic [15:0] flags;
    logic [15:0] qd;
    logic [6:0]  len;
    logic [6:0]  fault_at;
    verdict_e    verdict;
  } query_row_t;

  localparam int NUM_ROWS = 6;
  localparam query_row_t QUERY_TABLE [NUM_ROWS] = '{
    '{SET_BASE,  16'h0000, 16'h0000, 16'h0001, 7'd46, NO_FAULT, V_ANSWER},
    '{SET_FULL,  16'hFFFF, 16'h07FF, 16'hFFFF, 7'd46, 7'd45,    V_ANSWER},
    '{SET_KEEP,  16'h1234, 16'h8800, 16'h0001, 7'd46, NO_FAULT, V_SILENT},
    '{SET_KEEP,  16'h1237, 16'h0110, 16'h0000, 7'd46, NO_FAULT, V_SILENT},
    '{SET_KEEP,  16'hA5C3, 16'h0110, 16'h0001, 7'd45, NO_FAULT, V_SILENT},
    '{SET_ODD,   16'h0002, 16'h0110, 16'h0001, 7'd46, 7'd13,    V_SILENT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  nbq_pkg::in_word_t   in_word = '0;
  logic                pop = 1'b0;
  logic                empty;
  nbq_pkg::out_word_t  out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [63:0]         cfg_data = '0;

  name_cfg_t           live_cfg = '0;
  logic [5:0]          rx_pos = '0;
  logic [15:0]         rx_tid = '0;
  logic                flags_ok = 1'b1;
  logic                qd_seen = 1'b0;
  logic                name_match = 1'b1;
  nbq_pkg::out_word_t  answer_words[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;

  netbios_name_query_responder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .pop         (pop),
    .empty       (empty),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [7:0] name_code(input int k);
    int i;
    logic [7:0] r;
    i = k / 2;
    if (i >= 15) begin
      r = 8'h00;
    end else if (i >= live_cfg.len) begin
      r = 8'h20;
    end else begin
      r = (i < 8) ? live_cfg.first[8*(7-i) +: 8] : live_cfg.last[8*(14-i) +: 8];
      if (r >= "a" && r <= "z") begin
        r = r - 8'h20;
      end
    end
    return 8'h41 + {4'h0, (k % 2 == 1) ? r[3:0] : r[7:4]};
  endfunction

  function automatic logic [7:0] answer_byte(input int p, input logic [15:0] tid);
    logic [7:0] b;
    case (p)
      0:       b = tid[15:8];
      1:       b = tid[7:0];
      2:       b = 8'h85;
      7:       b = 8'h01;
      12:      b = 8'h20;
      47:      b = 8'h20;
      49:      b = 8'h01;
      52:      b = 8'h01;
      53:      b = 8'h2C;
      55:      b = 8'h06;
      58:      b = live_cfg.addr[31:24];
      59:      b = live_cfg.addr[23:16];
      60:      b = live_cfg.addr[15:8];
      61:      b = live_cfg.addr[7:0];
      default: b = (p > LEN_BYTE_POS && p <= NAME_END_POS) ? name_code(p - 13) : 8'h00;
    endcase
    return b;
  endfunction

  // Returns 1 when this word closes a query that earns an answer.
  function automatic bit absorb_byte(input nbq_pkg::in_word_t w, output logic [15:0] tid_o);
    logic [7:0] b;
    bit hit;
    b = w.rx_byte;
    if (rx_pos == 6'd0) begin
      rx_tid[15:8] = b;
    end else if (rx_pos == 6'd1) begin
      rx_tid[7:0] = b;
    end else if (rx_pos == 6'd2) begin
      if (b[7:3] != 5'd0) flags_ok = 1'b0;
    end else if (rx_pos == 6'd4 || rx_pos == 6'd5) begin
      if (b != 8'h00) qd_seen = 1'b1;
    end else if (rx_pos == LEN_BYTE_POS) begin
      if (b != 8'h20) name_match = 1'b0;
    end else if (rx_pos > LEN_BYTE_POS && rx_pos <= NAME_END_POS) begin
      if (b != name_code(rx_pos - LEN_BYTE_POS - 1)) name_match = 1'b0;
    end
    tid_o = rx_tid;
    if (!w.end_of_packet) begin
      if (rx_pos != 6'd63) rx_pos = rx_pos + 6'd1;
      return 1'b0;
    end
    hit = (rx_pos >= nbq_pkg::MIN_LAST_POS) && flags_ok && qd_seen && name_match;
    rx_pos = '0;
    rx_tid = '0;
    flags_ok = 1'b1;
    qd_seen = 1'b0;
    name_match = 1'b1;
    return hit;
  endfunction

  function automatic byte_q_t build_query(input logic [15:0] tid, input logic [15:0] flags,
                                          input logic [15:0] qd, input int len,
                                          input int fault_at);
    byte_q_t pkt;
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      case (p)
        0:            b = tid[15:8];
        1:            b = tid[7:0];
        2:            b = flags[15:8];
        3:            b = flags[7:0];
        4:            b = qd[15:8];
        5:            b = qd[7:0];
        LEN_BYTE_POS: b = 8'h20;
        default: begin
          if (p > LEN_BYTE_POS && p <= NAME_END_POS) begin
            b = name_code(p - LEN_BYTE_POS - 1);
          end else begin
            b = 8'($urandom);
          end
        end
      endcase
      if (p == fault_at) b = b ^ 8'($urandom_range(1, 255));
      pkt.push_back(b);
    end
    return pkt;
  endfunction

  function automatic name_cfg_t preset_cfg(input preset_e s);
    name_cfg_t r;
    case (s)
      SET_BASE:  r = '{64'h6E62_7173_6572_7665, 56'h0, 4'd8, 32'hC0A8_010A};
      SET_FULL:  r = '{64'h0061_7A7B_6040_5BFF, 56'h61_6263_7A00_207F, 4'd15, 32'hFFFF_FFFF};
      SET_BLANK: r = '{64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 4'd0, 32'h0};
      default:   r = '{64'h3031_2D5F_415A_617A, 56'h80_9FE0_FE0A_0D09, 4'd11, 32'h0A00_0001};
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      nbq_pkg::CFG_NAME_FIRST: live_cfg.first = data;
      nbq_pkg::CFG_NAME_LAST:  live_cfg.last = data[55:0];
      nbq_pkg::CFG_NAME_LEN:   live_cfg.len = data[3:0];
      nbq_pkg::CFG_LOCAL_ADDR: live_cfg.addr = data[31:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input name_cfg_t s);
    write_reg(nbq_pkg::CFG_NAME_FIRST, s.first);
    write_reg(nbq_pkg::CFG_NAME_LAST, {8'($urandom), s.last});
    write_reg(nbq_pkg::CFG_NAME_LEN, {$urandom, 28'($urandom), s.len});
    write_reg(nbq_pkg::CFG_LOCAL_ADDR, {$urandom, s.addr});
    write_reg(8'($urandom_range(nbq_pkg::CFG_LOCAL_ADDR + 1, 255)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (answer_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  bit calm_in = 1'b0;

  task automatic send_packet(input byte_q_t pkt, input verdict_e verdict, output bit answered);
    nbq_pkg::in_word_t w;
    nbq_pkg::out_word_t a;
    logic [15:0] tid;
    int gap;
    bit hit;
    answered = 1'b0;
    foreach (pkt[i]) begin
      w.rx_byte = pkt[i];
      w.end_of_packet = (i == pkt.size() - 1);
      if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
      gap = draw_gap(calm_in);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      push <= 1'b1;
      in_word <= w;
      do @(posedge clk_i); while (full);
      hit = absorb_byte(w, tid);
      if (w.end_of_packet && (verdict == V_ANSWER || (verdict == V_MODEL && hit))) begin
        answered = 1'b1;
        for (int p = 0; p < ANSWER_WORDS; p++) begin
          a.tx_byte = answer_byte(p, tid);
          a.tx_last = (p == ANSWER_WORDS - 1);
          answer_words.push_back(a);
        end
      end
    end
  endtask

  initial begin : answer_check
    nbq_pkg::out_word_t want;
    int gap;
    bit calm;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      gap = draw_gap(calm);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (answer_words.size() == 0) begin
        flag_mismatch($sformatf("word %h arrived with no answer pending", out_word));
      end else begin
        want = answer_words.pop_front();
        if (out_word.tx_byte !== want.tx_byte) begin
          flag_mismatch($sformatf("tx_byte expected %h got %h", want.tx_byte, out_word.tx_byte));
        end
        if (out_word.tx_last !== want.tx_last) begin
          flag_mismatch($sformatf("tx_last expected %b got %b", want.tx_last, out_word.tx_last));
        end
      end
    end
  end

  initial begin : stimulus
    query_row_t row;
    byte_q_t pkt;
    name_cfg_t rnd;
    logic [15:0] flags;
    logic [15:0] qd;
    int len;
    int fault_at;
    int kind;
    int sent_items;
    bit fresh_cfg;
    bit answered;
    sent_items = 0;
    fresh_cfg = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = QUERY_TABLE[r];
      if (row.preset != SET_KEEP) begin
        settle();
        apply_config(preset_cfg(row.preset));
      end
      pkt = build_query(row.tid, row.flags, row.qd, row.len, row.fault_at);
      send_packet(pkt, row.verdict, answered);
      sent_items += pkt.size();
    end

    while (sent_items < ITEM_TARGET) begin
      if (fresh_cfg || $urandom_range(0, 5) == 0) begin
        fresh_cfg = 1'b0;
        rnd.first = {$urandom, $urandom};
        rnd.last = 56'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0) begin
          rnd.len = $urandom_range(0, 1) ? nbq_pkg::MAX_NAME_CHARS : 4'd0;
        end else begin
          rnd.len = 4'($urandom_range(0, 15));
        end
        rnd.addr = $urandom;
        settle();
        apply_config(rnd);
      end
      kind = $urandom_range(0, 99);
      flags = {5'b00000, 11'($urandom)};
      qd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 3));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(47, 72)
                                        : $urandom_range(MIN_QUERY_LEN, 48);
      fault_at = NO_FAULT;
      if (kind < 70) begin
      end else if (kind < 76) begin
        flags[11 + $urandom_range(0, 4)] = 1'b1;
      end else if (kind < 81) begin
        qd = 16'h0000;
      end else if (kind < 89) begin
        fault_at = $urandom_range(LEN_BYTE_POS, NAME_END_POS);
      end else if (kind < 95) begin
        len = $urandom_range(1, MIN_QUERY_LEN - 1);
      end else begin
        len = $urandom_range(1, 72);
      end
      pkt = build_query(16'($urandom), flags, qd, len, fault_at);
      if (kind >= 95) begin
        foreach (pkt[i]) pkt[i] = 8'($urandom);
      end
      send_packet(pkt, V_MODEL, answered);
      sent_items += pkt.size();
    end

    settle();
    repeat (END_HOLD) @(posedge clk_i);
    mismatches += answer_words.size();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
